// ===== rtl/core/cdss_pkg.sv =====
// Shared types and constants for the coupled diffusion stencil step block.
// No dependencies; used by coupled_diffusion_stencil_step.
package cdss_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int GAIN_W     = 17;
	localparam int STEPS_W    = 11;
	localparam int NPTS_W     = 7;
	localparam int FIELD_W    = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_CNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NPOINTS   = 2'd3;

	localparam logic [GAIN_W-1:0]  RST_DIFF_GAIN = 17'd0;
	localparam logic [GAIN_W-1:0]  RST_TIME_STEP = 17'd6554;
	localparam logic [STEPS_W-1:0] RST_STEP_CNT  = 11'd11;
	localparam logic [NPTS_W-1:0]  RST_NPOINTS   = 7'd64;
	localparam logic [NPTS_W-1:0]  MIN_POINTS    = 7'd3;

	typedef enum logic [9:0] {
		S_LOAD  = 10'b00_0000_0001,
		S_RD    = 10'b00_0000_0010,
		S_SHIFT = 10'b00_0000_0100,
		S_M1    = 10'b00_0000_1000,
		S_M2    = 10'b00_0001_0000,
		S_M3    = 10'b00_0010_0000,
		S_WR    = 10'b00_0100_0000,
		S_ERD   = 10'b00_1000_0000,
		S_EWAIT = 10'b01_0000_0000,
		S_EOUT  = 10'b10_0000_0000
	} state_t;

endpackage

// ===== rtl/core/cdss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cdss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/coupled_diffusion_stencil_step.sv =====
// Coupled reaction-diffusion stencil on a periodic 1D grid, U and V in Q16.16.
// Load: one point per cycle. Each time step primes the three-point window, then
// sweeps N points through read, shift, three multiply phases and write-back; the
// grid RAM has a single read port, shared by the window reads and emission.
// Emission: one point at a time, held until the sink is ready. Async active-low reset
// clears control state and config registers; the grid RAM is not cleared.
module coupled_diffusion_stencil_step #(
	parameter int MAX_POINTS = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cdss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cdss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [63:0]                       s_axis_tdata,  // u_in [31:0], v_in [63:32]
	input  logic                              s_axis_tlast,  // last_in
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [63:0]                       m_axis_tdata,  // u_out [31:0], v_out [63:32]
	output logic                              m_axis_tlast   // last_out
);

	localparam int VB   = VALUE_BITS;
	localparam int AW_A = VB + 2;
	localparam int BW   = (VB + 2 > 18) ? VB + 2 : 18;
	localparam int PW   = AW_A + BW;
	localparam int IW   = $clog2(MAX_POINTS);
	localparam int NW   = $clog2(MAX_POINTS + 1);
	localparam int KW   = $clog2(MAX_POINTS + 2);
	localparam int RAW  = $clog2(2 * MAX_POINTS);
	localparam int FB   = cdss_pkg::FRAC_BITS;

	// saturate a wide signed value to VB bits
	function automatic logic [VB-1:0] sat_vb(input logic signed [PW-1:0] s);
		logic [PW-VB:0] hi;
		hi = s[PW-1:VB-1];
		if ((&hi) || !(|hi)) return s[VB-1:0];
		else if (s[PW-1]) return {1'b1, {(VB-1){1'b0}}};
		else return {1'b0, {(VB-1){1'b1}}};
	endfunction

	function automatic logic [31:0] sat_32(input logic signed [PW-1:0] s);
		logic [PW-32:0] hi;
		hi = s[PW-1:31];
		if ((&hi) || !(|hi)) return s[31:0];
		else if (s[PW-1]) return {1'b1, {31{1'b0}}};
		else return {1'b0, {31{1'b1}}};
	endfunction

	function automatic logic [RAW-1:0] grid_addr(input logic bsel, input logic [IW-1:0] idx);
		if (bsel) return RAW'(MAX_POINTS) + RAW'(idx);
		else return RAW'(idx);
	endfunction

	cdss_pkg::state_t state_q;

	logic [cdss_pkg::GAIN_W-1:0]  gain_q, dt_q;
	logic [cdss_pkg::STEPS_W-1:0] step_cnt_q, steps_q;
	logic [cdss_pkg::NPTS_W-1:0]  npts_q;
	logic [NW-1:0] n_eff, load_idx_q;
	logic [KW-1:0] k_q, k_end;
	logic [IW-1:0] e_idx_q, rd_idx, pt_idx, n_last;
	logic          active_q;

	logic [2*VB-1:0] win_l_q, win_c_q, win_r_q;
	logic signed [VB-1:0] u_c, v_c, u_l, v_l, u_r, v_r;
	logic signed [AW_A-1:0] lap_u, lap_v;
	logic signed [AW_A-1:0] au, av;
	logic signed [BW-1:0]   bu, bv;
	logic signed [PW-1:0]   mul_u, mul_v, prod_u_q, prod_v_q;
	logic signed [PW-1:0]   sum_u, sum_v;
	logic [VB-1:0] r0_u_q, r0_v_q, lg_u_q, lg_v_q, ru, rv;

	logic            ram_we;
	logic [RAW-1:0]  ram_waddr, ram_raddr;
	logic [2*VB-1:0] ram_wdata, ram_rdata;

	logic [31:0] out_u_q, out_v_q;
	logic        out_last_q;

	logic [BW-1:0] one_q16;
	logic [BW-1:0] gain_b, dt_b;
	logic [VB-1:0] in_u, in_v;

	assign one_q16 = {{(BW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
	assign gain_b  = {{(BW-cdss_pkg::GAIN_W){1'b0}}, gain_q};
	assign dt_b    = {{(BW-cdss_pkg::GAIN_W){1'b0}}, dt_q};

	// clamp the point count into the supported range
	always_comb begin
		if (npts_q < cdss_pkg::MIN_POINTS) n_eff = NW'(cdss_pkg::MIN_POINTS);
		else if (npts_q > cdss_pkg::NPTS_W'(MAX_POINTS)) n_eff = NW'(MAX_POINTS);
		else n_eff = NW'(npts_q);
	end

	assign n_last = IW'(n_eff - NW'(1));
	assign k_end  = KW'(n_eff) + KW'(1);
	assign pt_idx = IW'(k_q - KW'(2));

	// window read order: N-1, 0, 1, ..., N-1, 0
	always_comb begin
		if (k_q == '0) rd_idx = n_last;
		else if (k_q - KW'(1) == KW'(n_eff)) rd_idx = '0;
		else rd_idx = IW'(k_q - KW'(1));
	end

	assign u_l = win_l_q[VB-1:0];
	assign v_l = win_l_q[2*VB-1:VB];
	assign u_c = win_c_q[VB-1:0];
	assign v_c = win_c_q[2*VB-1:VB];
	assign u_r = win_r_q[VB-1:0];
	assign v_r = win_r_q[2*VB-1:VB];

	assign lap_u = AW_A'(u_l) + AW_A'(u_r) - (AW_A'(u_c) <<< 1);
	assign lap_v = AW_A'(v_l) + AW_A'(v_r) - (AW_A'(v_c) <<< 1);

	// operand selection for the two multiplier lanes
	always_comb begin
		case (state_q)
			cdss_pkg::S_M1: begin
				au = AW_A'(v_c);
				bu = BW'(u_c) + one_q16;
				av = AW_A'(u_c);
				bv = BW'(v_c) + one_q16;
			end
			cdss_pkg::S_M2: begin
				au = lap_u;
				bu = gain_b;
				av = lap_v;
				bv = gain_b;
			end
			cdss_pkg::S_M3: begin
				au = AW_A'($signed(r0_u_q));
				bu = dt_b;
				av = AW_A'($signed(r0_v_q));
				bv = dt_b;
			end
			default: begin
				au = '0;
				bu = '0;
				av = '0;
				bv = '0;
			end
		endcase
	end

	assign mul_u = au * bu;
	assign mul_v = av * bv;

	assign ru    = sat_vb(prod_u_q >>> FB);
	assign rv    = sat_vb(prod_v_q >>> FB);
	assign sum_u = PW'(u_c) + PW'($signed(lg_u_q)) - PW'($signed(ru));
	assign sum_v = PW'(v_c) + PW'($signed(lg_v_q)) + PW'($signed(rv));

	assign in_u = sat_vb(PW'($signed(s_axis_tdata[31:0])));
	assign in_v = sat_vb(PW'($signed(s_axis_tdata[63:32])));

	// RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = grid_addr(active_q, load_idx_q[IW-1:0]);
		ram_wdata = {in_v, in_u};
		ram_raddr = grid_addr(active_q, rd_idx);
		case (state_q)
			cdss_pkg::S_LOAD: begin
				ram_we = s_axis_tvalid && (load_idx_q < n_eff);
			end
			cdss_pkg::S_WR: begin
				ram_we    = 1'b1;
				ram_waddr = grid_addr(!active_q, pt_idx);
				ram_wdata = {sat_vb(sum_v), sat_vb(sum_u)};
			end
			cdss_pkg::S_ERD: begin
				ram_raddr = grid_addr(active_q, e_idx_q);
			end
			default: begin
			end
		endcase
	end

	cdss_ram #(
		.WIDTH(2 * VB),
		.DEPTH(2 * MAX_POINTS)
	) u_grid_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= cdss_pkg::RST_DIFF_GAIN;
			dt_q       <= cdss_pkg::RST_TIME_STEP;
			step_cnt_q <= cdss_pkg::RST_STEP_CNT;
			npts_q     <= cdss_pkg::RST_NPOINTS;
		end else if (cfg_we) begin
			case (cfg_index)
				cdss_pkg::CFG_DIFF_GAIN: gain_q <= cfg_data;
				cdss_pkg::CFG_TIME_STEP: dt_q <= cfg_data;
				cdss_pkg::CFG_STEP_CNT:  step_cnt_q <= cfg_data[cdss_pkg::STEPS_W-1:0];
				cdss_pkg::CFG_NPOINTS:   npts_q <= cfg_data[cdss_pkg::NPTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cdss_pkg::S_LOAD;
			load_idx_q <= '0;
			k_q        <= '0;
			steps_q    <= '0;
			e_idx_q    <= '0;
			active_q   <= 1'b0;
		end else begin
			case (state_q)
				cdss_pkg::S_LOAD: begin
					if (s_axis_tvalid) begin
						if (s_axis_tlast) begin
							load_idx_q <= '0;
							k_q        <= '0;
							steps_q    <= '0;
							e_idx_q    <= '0;
							if (step_cnt_q == '0) state_q <= cdss_pkg::S_ERD;
							else state_q <= cdss_pkg::S_RD;
						end else if (load_idx_q < n_eff) begin
							load_idx_q <= load_idx_q + NW'(1);
						end
					end
				end
				cdss_pkg::S_RD: state_q <= cdss_pkg::S_SHIFT;
				cdss_pkg::S_SHIFT: begin
					if (k_q >= KW'(2)) begin
						state_q <= cdss_pkg::S_M1;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= cdss_pkg::S_RD;
					end
				end
				cdss_pkg::S_M1: state_q <= cdss_pkg::S_M2;
				cdss_pkg::S_M2: state_q <= cdss_pkg::S_M3;
				cdss_pkg::S_M3: state_q <= cdss_pkg::S_WR;
				cdss_pkg::S_WR: begin
					if (k_q == k_end) begin
						// sweep done: swap buffers
						active_q <= !active_q;
						k_q      <= '0;
						steps_q  <= steps_q + cdss_pkg::STEPS_W'(1);
						if (steps_q + cdss_pkg::STEPS_W'(1) == step_cnt_q) begin
							state_q <= cdss_pkg::S_ERD;
						end else begin
							state_q <= cdss_pkg::S_RD;
						end
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= cdss_pkg::S_RD;
					end
				end
				cdss_pkg::S_ERD:   state_q <= cdss_pkg::S_EWAIT;
				cdss_pkg::S_EWAIT: state_q <= cdss_pkg::S_EOUT;
				cdss_pkg::S_EOUT: begin
					if (m_axis_tready) begin
						if (out_last_q) begin
							state_q <= cdss_pkg::S_LOAD;
						end else begin
							e_idx_q <= e_idx_q + IW'(1);
							state_q <= cdss_pkg::S_ERD;
						end
					end
				end
				default: state_q <= cdss_pkg::S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			cdss_pkg::S_SHIFT: begin
				win_l_q <= win_c_q;
				win_c_q <= win_r_q;
				win_r_q <= ram_rdata;
			end
			cdss_pkg::S_M1: begin
				prod_u_q <= mul_u;
				prod_v_q <= mul_v;
			end
			cdss_pkg::S_M2: begin
				r0_u_q   <= sat_vb(prod_u_q >>> FB);
				r0_v_q   <= sat_vb(prod_v_q >>> FB);
				prod_u_q <= mul_u;
				prod_v_q <= mul_v;
			end
			cdss_pkg::S_M3: begin
				lg_u_q   <= sat_vb(prod_u_q >>> FB);
				lg_v_q   <= sat_vb(prod_v_q >>> FB);
				prod_u_q <= mul_u;
				prod_v_q <= mul_v;
			end
			cdss_pkg::S_EWAIT: begin
				out_u_q    <= sat_32(PW'($signed(ram_rdata[VB-1:0])));
				out_v_q    <= sat_32(PW'($signed(ram_rdata[2*VB-1:VB])));
				out_last_q <= (e_idx_q == n_last);
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == cdss_pkg::S_LOAD);
	assign m_axis_tvalid = (state_q == cdss_pkg::S_EOUT);
	assign m_axis_tdata  = {out_v_q, out_u_q};
	assign m_axis_tlast  = out_last_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output sides active together");

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == cdss_pkg::S_LOAD || state_q == cdss_pkg::S_WR))
		else $error("grid write outside load or write-back");

	a_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdss_pkg::S_WR && k_q == k_end) |=> (active_q != $past(active_q)))
		else $error("buffers not swapped after sweep");

endmodule
